// ----- rtl/core/npsc_pkg.sv -----
// types and constants shared by the nearest point search core
package npsc_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SqW     = 2 * CoordW;
  localparam int unsigned DistW   = SqW + 1;
  localparam int unsigned OutIdxW = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_t;

endpackage

// ----- rtl/core/nearest_point_search_core.sv -----
// nearest point search core: point table with linear nearest-neighbor scan
//
//  channel  dir  tdata (low bit up)                                  tuser
//  s_axis   in   coord_x[15:0] coord_y[31:16]                        command[1:0]
//  m_axis   out  near_x[15:0] near_y[31:16] near_index[41:32]        status[1:0]
//                near_dist_sq[74:42] zero[79:75]
//
//  clear, insert, an unused command and a query on an empty table answer in the cycle after the item
//  a query over n stored points reads one table entry per cycle through the
//  single memory read port, then passes the read and the three stage distance
//  pipeline before its answer is ready
//  rst clears the point count and the control state; the table is not cleared
//  a new item is taken only when idle and the result register is free or
//  emptying in that cycle, so a stalled m_axis holds off s_axis
module nearest_point_search_core
  import npsc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // coord_x, coord_y
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // near_x, near_y, near_index, near_dist_sq, pad
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_NODES);

  state_t state;
  state_t state_next;

  // input side decode
  logic   in_fire;
  cmd_t   cmd;
  point_t in_pt;
  logic   table_full;
  logic   table_empty;

  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign cmd         = cmd_t'(s_axis_tuser);
  assign in_pt.x     = s_axis_tdata[15:0];
  assign in_pt.y     = s_axis_tdata[31:16];

  logic [CNT_W-1:0] point_count;
  assign table_full  = (point_count == CntMax);
  assign table_empty = (point_count == '0);

  // scan sequencer
  logic [CNT_W-1:0] issue_cnt;
  logic             issue_en;
  logic             issue_last;
  logic             result_done;
  logic             pipe_busy;
  point_t           query;

  assign issue_last = ((issue_cnt + CNT_W'(1)) == point_count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && cmd == CMD_QUERY && !table_empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue_en      = 1'b0;
    result_done   = 1'b0;
    case (state)
      S_IDLE:  s_axis_tready = ~m_axis_tvalid | m_axis_tready;
      S_SCAN:  issue_en = 1'b1;
      S_DRAIN: result_done = ~pipe_busy;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // point count and query capture
  logic mem_wr;
  assign mem_wr = in_fire && cmd == CMD_INSERT && !table_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (in_fire && cmd == CMD_CLEAR) begin
      point_count <= '0;
    end else if (mem_wr) begin
      point_count <= point_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
    end else if (in_fire) begin
      issue_cnt <= '0;
    end else if (issue_en) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      query <= in_pt;
    end
  end

  // point table
  point_t           rd_pt;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;

  npsc_point_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (point_count[IDX_W-1:0]),
    .wr_data (in_pt),
    .rd_en   (issue_en),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (rd_pt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[IDX_W-1:0];
  end

  // shared distance unit
  logic             d_valid;
  point_t           d_pt;
  logic [IDX_W-1:0] d_idx;
  logic [DistW-1:0] d_dist;
  logic             d_busy;

  npsc_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_pt     (rd_pt),
    .in_idx    (rd_idx),
    .query     (query),
    .out_valid (d_valid),
    .out_pt    (d_pt),
    .out_idx   (d_idx),
    .out_dist  (d_dist),
    .busy      (d_busy)
  );

  assign pipe_busy = rd_valid | d_busy;

  // running best; first point always taken, ties go to the later index
  logic             best_valid;
  point_t           best_pt;
  logic [IDX_W-1:0] best_idx;
  logic [DistW-1:0] best_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (in_fire) begin
      best_valid <= 1'b0;
    end else if (d_valid) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && (!best_valid || d_dist <= best_dist)) begin
      best_pt   <= d_pt;
      best_idx  <= d_idx;
      best_dist <= d_dist;
    end
  end

  // result register
  logic                  imm_result;
  status_t               imm_status;
  logic [IDX_W+OutIdxW-1:0] best_idx_ext;

  assign imm_result   = in_fire && !(cmd == CMD_QUERY && !table_empty);
  assign best_idx_ext = {{OutIdxW{1'b0}}, best_idx};

  always_comb begin
    imm_status = ST_OK;
    case (cmd)
      CMD_INSERT: imm_status = table_full ? ST_FULL : ST_OK;
      CMD_QUERY:  imm_status = table_empty ? ST_EMPTY : ST_OK;
      default:    imm_status = ST_OK;
    endcase
  end

  status_t            out_status;
  point_t             out_pt;
  logic [OutIdxW-1:0] out_idx;
  logic [DistW-1:0]   out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (imm_result || result_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_done) begin
      out_status <= ST_OK;
      out_pt     <= best_pt;
      out_idx    <= best_idx_ext[OutIdxW-1:0];
      out_dist   <= best_dist;
    end else if (imm_result) begin
      out_status <= imm_status;
      out_pt     <= '0;
      out_idx    <= '0;
      out_dist   <= '0;
    end
  end

  assign m_axis_tdata = {5'b0, out_dist, out_idx, out_pt.y, out_pt.x};
  assign m_axis_tuser = out_status;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CntMax)
    else $error("point count above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    issue_en |-> issue_cnt < point_count)
    else $error("scan address past last stored point");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_INSERT && !table_full)
      |=> point_count == $past(point_count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_pipe_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pipe_busy)
    else $error("distance pipeline active while idle");

endmodule

// ----- rtl/core/npsc_point_mem.sv -----
// point table memory, one write port and one registered read port
module npsc_point_mem
  import npsc_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  point_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output point_t            rd_data
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/npsc_dist_unit.sv -----
// shared squared distance unit: subtract, square, add over three stages
module npsc_dist_unit
  import npsc_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  point_t           in_pt,
  input  logic [IDX_W-1:0] in_idx,
  input  point_t           query,
  output logic             out_valid,
  output point_t           out_pt,
  output logic [IDX_W-1:0] out_idx,
  output logic [DistW-1:0] out_dist,
  output logic             busy
);

  logic                    valid_a;
  logic signed [DiffW-1:0] dx;
  logic signed [DiffW-1:0] dy;
  point_t                  pt_a;
  logic [IDX_W-1:0]        idx_a;

  logic                    valid_b;
  logic [SqW-1:0]          sqx;
  logic [SqW-1:0]          sqy;
  point_t                  pt_b;
  logic [IDX_W-1:0]        idx_b;

  logic signed [2*DiffW-1:0] prod_x;
  logic signed [2*DiffW-1:0] prod_y;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    dx       <= DiffW'($signed(in_pt.x)) - DiffW'($signed(query.x));
    dy       <= DiffW'($signed(in_pt.y)) - DiffW'($signed(query.y));
    pt_a     <= in_pt;
    idx_a    <= in_idx;
    // |d| < 2^16, so the square fits in the low 32 bits
    sqx      <= prod_x[SqW-1:0];
    sqy      <= prod_y[SqW-1:0];
    pt_b     <= pt_a;
    idx_b    <= idx_a;
    out_dist <= {1'b0, sqx} + {1'b0, sqy};
    out_pt   <= pt_b;
    out_idx  <= idx_b;
  end

  assign busy = valid_a | valid_b | out_valid;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the nearest point search core
`timescale 1ns / 100ps

module testbench;
  import npsc_pkg::*;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned RandomItems = 520;

  // command value with no meaning, the core must answer it and change nothing
  localparam logic [1:0] CmdUnused = 2'd3;

  // ways of picking a coordinate
  localparam int unsigned CoordSpread  = 0;
  localparam int unsigned CoordCluster = 1;
  localparam int unsigned CoordEdge    = 2;

  // one answer of the core, field for field
  typedef struct packed {
    status_t            status;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         index;
    logic [32:0]        dist_sq;
  } answer_t;

  // keeps its own copy of the point table and the answers still owed
  class search_checker;
    point_t      pts[MaxPoints];
    int unsigned stored;
    answer_t     pending[$];
    int unsigned mismatches;

    function new();
      stored     = 0;
      mismatches = 0;
    endfunction

    function longint sq_span(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    // work out what one accepted command must produce and update the table
    function void take_command(logic [1:0] cmd, logic signed [15:0] qx,
                               logic signed [15:0] qy);
      answer_t     a;
      longint      best_d;
      longint      d;
      int unsigned best;
      a = '0;
      if (cmd == CMD_CLEAR) begin
        stored = 0;
      end else if (cmd == CMD_INSERT) begin
        if (stored < MaxPoints) begin
          pts[stored].x = qx;
          pts[stored].y = qy;
          stored++;
        end else begin
          a.status = ST_FULL;
        end
      end else if (cmd == CMD_QUERY) begin
        if (stored == 0) begin
          a.status = ST_EMPTY;
        end else begin
          best   = 0;
          best_d = sq_span(pts[0].x, qx) + sq_span(pts[0].y, qy);
          // later index wins a tie
          for (int unsigned i = 0; i < stored; i++) begin
            d = sq_span(pts[i].x, qx) + sq_span(pts[i].y, qy);
            if (d <= best_d) begin
              best_d = d;
              best   = i;
            end
          end
          a.status  = ST_OK;
          a.x       = pts[best].x;
          a.y       = pts[best].y;
          a.index   = best[9:0];
          a.dist_sq = best_d[32:0];
        end
      end
      pending = {pending, a};
    endfunction

    // compare one accepted result with the oldest answer owed
    function void check_answer(logic [79:0] data, logic [1:0] user);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: status %0d data %h",
                   $realtime, user, data);
        return;
      end
      want = pending.pop_front();
      if (user !== want.status || data[15:0] !== want.x || data[31:16] !== want.y ||
          data[41:32] !== want.index || data[74:42] !== want.dist_sq ||
          data[79:75] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch  expected status %0d x %0d y %0d index %0d dist %0d",
                   $realtime, want.status, want.x, want.y, want.index, want.dist_sq);
          $display("%0t:           actual   status %0d x %0d y %0d index %0d dist %0d pad %h",
                   $realtime, user, $signed(data[15:0]), $signed(data[31:16]),
                   data[41:32], data[74:42], data[79:75]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // coord_x, coord_y
  logic [1:0]  s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // near_x, near_y, near_index, near_dist_sq, pad
  logic [1:0]  m_axis_tuser;   // status

  // no random idling on either side while this is set
  bit steady;

  search_checker board = new();

  nearest_point_search_core #(
    .MAX_NODES(MaxPoints)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: values are read before the edge updates them, then tready is redrawn
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_answer(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= steady || ($urandom_range(99) >= 6);
    end
  end

  // offer one item and hold it until the core takes it
  // called at a rising edge, returns at the edge where the item was taken
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] x,
                           input logic signed [15:0] y);
    while (!steady && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.take_command(cmd, x, y);
  endtask

  function automatic logic signed [15:0] pick_coord(input int unsigned mode);
    logic [15:0] v;
    case (mode)
      CoordCluster: v = 16'($urandom_range(8)) - 16'd4;
      CoordEdge: begin
        case ($urandom_range(3))
          0:       v = 16'h8000;
          1:       v = 16'h7fff;
          2:       v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // mostly full range, often a tight cluster so that hits and ties are common
  function automatic int unsigned pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CoordSpread;
    if (r < 85) return CoordCluster;
    return CoordEdge;
  endfunction

  task automatic run_directed();
    // query before anything was stored
    send_item(CMD_QUERY, 16'sd0, 16'sd0);
    send_item(CmdUnused, 16'sh1234, -16'sd77);
    // opposite corners
    send_item(CMD_INSERT, 16'sh7fff, 16'sh7fff);
    send_item(CMD_INSERT, -16'sh8000, -16'sh8000);
    send_item(CMD_QUERY, 16'sh7fff, 16'sh7fff);
    send_item(CMD_QUERY, -16'sh8000, -16'sh8000);
    // equally far from both corners, the later one must win
    send_item(CMD_QUERY, 16'sh7fff, -16'sh8000);
    send_item(CMD_QUERY, -16'sh8000, 16'sh7fff);
    // largest possible distance
    send_item(CMD_CLEAR, 16'sd0, 16'sd0);
    send_item(CMD_INSERT, -16'sh8000, -16'sh8000);
    send_item(CMD_QUERY, 16'sh7fff, 16'sh7fff);
    // same point stored again, the later copy wins
    send_item(CMD_INSERT, 16'sd0, 16'sd0);
    send_item(CMD_INSERT, 16'sd0, 16'sd0);
    send_item(CMD_QUERY, 16'sd0, 16'sd0);
    send_item(CMD_QUERY, 16'sd1, -16'sd1);
    // unused command must leave the table alone
    send_item(CmdUnused, 16'sh7fff, -16'sh8000);
    send_item(CMD_QUERY, -16'sd3, 16'sd2);
    // clear empties the table
    send_item(CMD_CLEAR, -16'sd1, -16'sd1);
    send_item(CMD_QUERY, 16'sd5, 16'sd5);
    send_item(CmdUnused, -16'sd1, -16'sd1);
    send_item(CMD_INSERT, 16'sd1, 16'sd1);
    send_item(CMD_QUERY, -16'sh8000, 16'sh7fff);
  endtask

  task automatic send_random_op(output bit counted);
    int unsigned        r;
    int unsigned        mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    r    = $urandom_range(99);
    mode = pick_mode();
    x    = pick_coord(mode);
    y    = pick_coord(mode);
    counted = 1'b1;
    if (r < 45) begin
      send_item(CMD_INSERT, x, y);
    end else if (r < 90) begin
      send_item(CMD_QUERY, x, y);
    end else if (r < 94) begin
      send_item(CMD_CLEAR, x, y);
    end else begin
      send_item(CmdUnused, x, y);
      counted = 1'b0;
    end
  endtask

  // runs of inserts, queries, clears and unused commands on small tables
  task automatic run_random();
    int unsigned done_items;
    int unsigned seg;
    int unsigned run_len;
    bit          counted;
    done_items = 0;
    seg        = 0;
    while (done_items < RandomItems) begin
      steady = (seg >= 20 && seg < 28);
      if (board.stored > 48 || $urandom_range(2) == 0) begin
        send_item(CMD_CLEAR, pick_coord(CoordSpread), pick_coord(CoordSpread));
        done_items++;
      end
      run_len = $urandom_range(20, 3);
      for (int unsigned i = 0; i < run_len; i++) begin
        send_random_op(counted);
        if (counted)
          done_items++;
      end
      seg++;
    end
    steady = 1'b0;
  endtask

  initial begin
    steady        = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_CLEAR;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    // wait for every owed answer, then a little longer for strays
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
